// ----- hw/rtl/sfr_pkg.sv -----
// shared constants, types and address function for the square frame rotator
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int MAX_SIDE   = 32;
  localparam int PIX_W      = 32;
  localparam int CFG_W      = 6;
  localparam int POS_W      = $clog2(MAX_SIDE);
  localparam int BANK_WORDS = MAX_SIDE * MAX_SIDE;
  localparam int STORE_WORDS = 2 * BANK_WORDS;
  localparam int ADDR_W     = $clog2(STORE_WORDS);
  localparam int SIDE_RST   = (32 > MAX_SIDE) ? MAX_SIDE : 32;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  function automatic addr_t store_addr(input logic bank, input pos_t row, input pos_t col);
    addr_t base;
    base = bank ? ADDR_W'(BANK_WORDS) : '0;
    return base + ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_SIDE)) + ADDR_W'(col);
  endfunction

endpackage

// ----- hw/rtl/sfr_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module sfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sfr_seq.sv -----
// raster position sequencer, bank control and output handshake
`timescale 1ns / 1ps
module sfr_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [sfr_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_last,
  output sfr_pkg::mem_req_t         mem_req
);

  sfr_pkg::pos_t side_m1_r, side_m1_nxt;
  sfr_pkg::pos_t row_r, row_nxt;
  sfr_pkg::pos_t col_r, col_nxt;
  logic          bank_r, bank_nxt;
  logic          ready_r, ready_nxt;
  logic          oval_r, oval_nxt;
  logic          last_r, last_nxt;
  logic          accept;
  logic          row_end, col_end;
  sfr_pkg::pos_t rd_col;

  // a held result blocks new reads so the ram output stays put
  assign in_stall = oval_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign col_end  = (col_r == side_m1_r);
  assign row_end  = (row_r == side_m1_r);
  assign rd_col   = side_m1_r - row_r;

  always_comb begin
    side_m1_nxt = side_m1_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    bank_nxt    = bank_r;
    ready_nxt   = ready_r;
    oval_nxt    = oval_r & out_stall;
    last_nxt    = last_r;
    if (accept) begin
      oval_nxt = ready_r;
      last_nxt = row_end & col_end;
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt   = '0;
          bank_nxt  = ~bank_r;
          ready_nxt = 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_we) begin
      // zero means one, anything above the store size is clamped
      if (cfg_wdata == '0) begin
        side_m1_nxt = '0;
      end else if (int'(cfg_wdata) > sfr_pkg::MAX_SIDE) begin
        side_m1_nxt = sfr_pkg::POS_W'(sfr_pkg::MAX_SIDE - 1);
      end else begin
        side_m1_nxt = sfr_pkg::POS_W'(int'(cfg_wdata) - 1);
      end
      row_nxt   = '0;
      col_nxt   = '0;
      ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_m1_r <= sfr_pkg::POS_W'(sfr_pkg::SIDE_RST - 1);
      row_r     <= '0;
      col_r     <= '0;
      bank_r    <= 1'b0;
      ready_r   <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      side_m1_r <= side_m1_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      bank_r    <= bank_nxt;
      ready_r   <= ready_nxt;
      oval_r    <= oval_nxt;
    end
    last_r <= last_nxt;
  end

  // write and read always target opposite banks, so no same-entry overlap
  always_comb begin
    mem_req.we    = accept;
    mem_req.waddr = sfr_pkg::store_addr(bank_r, row_r, col_r);
    mem_req.re    = accept & ready_r;
    mem_req.raddr = sfr_pkg::store_addr(~bank_r, col_r, rd_col);
  end

  assign out_valid = oval_r;
  assign out_last  = last_r;

endmodule

// ----- hw/rtl/square_frame_rotate_ccw90_top.sv -----
// top level of the square frame rotator (90 degrees anticlockwise)
`timescale 1ns / 1ps
// Takes square frames in raster order, one pixel per clock, and returns the
// previous frame rotated 90 degrees anticlockwise, also one pixel per clock.
// Each accepted pixel is written to one bank of a two-bank frame store while
// the rotated pixel at the same raster position is read from the other bank;
// the single write port and single read port of that store give a sustained
// rate of one transaction per cycle, each result in the cycle after its input.
// Results start only once a full frame of side*side pixels is stored;
// out_last_of_frame marks the final pixel of each rotated frame. Writing
// cfg_wdata (side 1..32, 0 is taken as 1) restarts framing from pixel 0 and
// suppresses output until a new frame is complete. in_stall rises only while
// a result is held by out_stall. No clearing pass is needed after reset.
module square_frame_rotate_ccw90_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sfr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [sfr_pkg::PIX_W-1:0] in_pixel_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sfr_pkg::PIX_W-1:0] out_pixel_out,
  output logic                             out_last_of_frame
);

  sfr_pkg::mem_req_t        mem_req;
  logic [sfr_pkg::PIX_W-1:0] rdata;

  sfr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (out_last_of_frame),
    .mem_req   (mem_req)
  );

  sfr_ram #(
    .WIDTH (sfr_pkg::PIX_W),
    .DEPTH (sfr_pkg::STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (in_pixel_in),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  assign out_pixel_out = rdata;

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// port-level checker for the square frame rotator, bound to the top level
`timescale 1ns / 1ps
module sfr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [sfr_pkg::PIX_W-1:0] out_pixel_out,
  input logic                      out_last_of_frame
);

  // a held result keeps its payload
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pixel_out) && $stable(out_last_of_frame))
    else $error("stalled result changed");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // results only follow input transactions
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && (!out_valid || !out_stall) |=> !out_valid)
    else $error("result appeared without an input transaction");

endmodule

bind square_frame_rotate_ccw90_top sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pixel_out     (out_pixel_out),
  .out_last_of_frame (out_last_of_frame)
);
